/* rtl/mwg_pkg.sv */
// Shared types, constants and the quarter-wave sine table builder for the
// waveform generator. No dependencies.
`default_nettype none

package mwg_pkg;

	localparam int MAX_CHANNELS    = 8;
	localparam int SINE_TABLE_BITS = 10;
	localparam int ROM_SIZE        = (1 << SINE_TABLE_BITS) + 1;
	localparam int ROM_AW          = SINE_TABLE_BITS + 1;
	localparam int CNT_W           = $clog2(MAX_CHANNELS + 1);
	localparam int CH_W            = 3;
	localparam int PHASE_W         = 32;
	localparam int GAIN_W          = 17;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int SAMPLE_W        = 32;

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd4;

	typedef enum logic [1:0] {
		SHAPE_SINE     = 2'd0,
		SHAPE_SQUARE   = 2'd1,
		SHAPE_TRIANGLE = 2'd2,
		SHAPE_SAW      = 2'd3
	} shape_t;

	// Code 3 is reserved and behaves like the 32-bit format
	typedef enum logic [1:0] {
		FMT_U8  = 2'd0,
		FMT_S16 = 2'd1,
		FMT_S32 = 2'd2
	} format_t;

	typedef struct packed {
		logic [1:0]         wave_shape;
		logic [1:0]         sample_format;
		logic [PHASE_W-1:0] phase_step;
		logic [GAIN_W-1:0]  amplitude_gain;
		logic [3:0]         channel_count;
	} cfg_t;

	// One tick request as handed from front to back
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [CNT_W-1:0]   count;
	} job_t;

	typedef logic [31:0] sine_rom_t [ROM_SIZE];

	// sin(pi/2 * k / 2^B) in Q.31, fixed-point Taylor series to the 17th power
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t          rom;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        mag;
		logic signed [64:0] sum;
		for (int k = 0; k < ROM_SIZE; k++) begin
			x   = (64'(k) * 64'd1686629713) >> SINE_TABLE_BITS;
			x2  = (x * x) >> 30;
			mag = x;
			sum = $signed({1'b0, x});
			mag = ((mag * x2) >> 30) / 64'd6;
			sum = sum - $signed({1'b0, mag});
			mag = ((mag * x2) >> 30) / 64'd20;
			sum = sum + $signed({1'b0, mag});
			mag = ((mag * x2) >> 30) / 64'd42;
			sum = sum - $signed({1'b0, mag});
			mag = ((mag * x2) >> 30) / 64'd72;
			sum = sum + $signed({1'b0, mag});
			mag = ((mag * x2) >> 30) / 64'd110;
			sum = sum - $signed({1'b0, mag});
			mag = ((mag * x2) >> 30) / 64'd156;
			sum = sum + $signed({1'b0, mag});
			mag = ((mag * x2) >> 30) / 64'd210;
			sum = sum - $signed({1'b0, mag});
			mag = ((mag * x2) >> 30) / 64'd272;
			sum = sum + $signed({1'b0, mag});
			if (sum < 0)
				sum = '0;
			if (sum > 65'sd1073741824)
				sum = 65'sd1073741824;
			rom[k] = 32'(sum * 2);
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

/* rtl/mwg_queue.sv */
// Two-entry request queue between front and back.
// Depends on mwg_pkg (job_t).
`default_nettype none

module mwg_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mwg_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output mwg_pkg::job_t      pop_data,
	output logic               empty
);

	mwg_pkg::job_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;

	assign full     = (fill_q == 2'd2);
	assign empty    = (fill_q == 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

/* rtl/mwg_front.sv */
// Front end: takes tick requests, owns the phase accumulator, resolves the
// channel count and queues one job per tick. Depends on mwg_pkg.
`default_nettype none

module mwg_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mwg_pkg::cfg_t                cfg,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         restart,
	output logic                              push,
	output mwg_pkg::job_t                     push_data,
	input  wire logic                         queue_full
);

	logic [mwg_pkg::PHASE_W-1:0] phase_q;
	logic [mwg_pkg::CNT_W-1:0]   count;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		if (cfg.channel_count == 4'd0)
			count = mwg_pkg::CNT_W'(1);
		else if (32'(cfg.channel_count) > mwg_pkg::MAX_CHANNELS)
			count = mwg_pkg::CNT_W'(mwg_pkg::MAX_CHANNELS);
		else
			count = mwg_pkg::CNT_W'(cfg.channel_count);
		push_data.phase = restart ? '0 : phase_q;
		push_data.count = count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= push_data.phase + cfg.phase_step;
		end
	end

endmodule

`default_nettype wire

/* rtl/mwg_back.sv */
// Back end: sequencer that turns a phase into a scaled, rounded, clamped
// sample and emits one copy per channel. Depends on mwg_pkg.
`default_nettype none

module mwg_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mwg_pkg::cfg_t                 cfg,
	input  wire logic                          queue_empty,
	input  wire mwg_pkg::job_t                 head,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [mwg_pkg::SAMPLE_W-1:0] sample_value,
	output logic [mwg_pkg::CH_W-1:0]           channel_index,
	output logic                               last_channel
);

	localparam int B        = mwg_pkg::SINE_TABLE_BITS;
	localparam int ROM_AW   = mwg_pkg::ROM_AW;
	localparam int CNT_W    = mwg_pkg::CNT_W;
	localparam int PROD_W   = 32 + mwg_pkg::GAIN_W;
	localparam int V_W      = PROD_W + 31;
	localparam int Q_W      = V_W - 47;
	localparam int R_W      = Q_W + 2;
	localparam int S_W      = R_W + 1;
	localparam logic [30:0] IDX_ROUND = 31'(1) << (29 - B);
	localparam logic [ROM_AW-1:0] IDX_TOP = ROM_AW'(1) << B;

	localparam logic signed [S_W-1:0] U8_OFFSET = S_W'(127);
	localparam logic signed [S_W-1:0] U8_LO     = S_W'(0);
	localparam logic signed [S_W-1:0] U8_HI     = S_W'(255);
	localparam logic signed [S_W-1:0] S16_LO    = -S_W'(32768);
	localparam logic signed [S_W-1:0] S16_HI    = S_W'(32767);
	localparam logic signed [S_W-1:0] S32_LO    = -(S_W'(1) <<< 31);
	localparam logic signed [S_W-1:0] S32_HI    = (S_W'(1) <<< 31) - S_W'(1);

	localparam mwg_pkg::sine_rom_t SINE_ROM = mwg_pkg::build_sine_rom();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAVE,
		ST_MUL,
		ST_SCALE,
		ST_ROUND,
		ST_CLAMP,
		ST_EMIT
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            ch_q;
	logic                        neg_q;
	logic [31:0]                 rom_q;
	logic [31:0]                 ns_mag_q;
	logic [31:0]                 mag_q;
	logic [PROD_W-1:0]           prod_q;
	logic [V_W-1:0]              v_q;
	logic signed [R_W-1:0]       round_q;
	logic                        valid_q;
	logic [mwg_pkg::SAMPLE_W-1:0] sample_q;
	logic                        last_q;

	logic [31:0]        ph;
	logic [30:0]        idx_sum;
	logic [ROM_AW-1:0]  idx_raw;
	logic [ROM_AW-1:0]  rom_addr;
	logic [31:0]        tri_u;
	logic [31:0]        tri_d;
	logic signed [33:0] tri_w;
	logic [31:0]        ns_mag;
	logic               neg;
	logic [V_W-1:0]     prod_ext;
	logic [V_W-1:0]     v_next;
	logic [Q_W-1:0]     q;
	logic               round_up;
	logic signed [R_W-1:0] round_next;
	logic signed [S_W-1:0] s_off;
	logic signed [S_W-1:0] s_lo;
	logic signed [S_W-1:0] s_hi;
	logic signed [S_W-1:0] s_clamped;

	assign pop = (state_q == ST_IDLE) && !queue_empty;

	always_comb begin
		ph = head.phase;

		// Sine: round low 30 bits to table resolution, mirror odd quadrants
		idx_sum  = {1'b0, ph[29:0]} + IDX_ROUND;
		idx_raw  = idx_sum[30:30-B];
		rom_addr = ph[30] ? (IDX_TOP - idx_raw) : idx_raw;

		tri_u = ph + 32'hC000_0000;
		tri_d = tri_u[31] ? {1'b0, tri_u[30:0]} : (32'h8000_0000 - tri_u);
		tri_w = 34'sh0_8000_0000 - $signed({1'b0, tri_d, 1'b0});

		// Sign follows the top phase bit, except the triangle's own offset phase
		neg = ph[31];
		case (cfg.wave_shape)
			mwg_pkg::SHAPE_SQUARE:   ns_mag = 32'h8000_0000;
			mwg_pkg::SHAPE_TRIANGLE: begin
				ns_mag = tri_w[33] ? 32'(-tri_w) : 32'(tri_w);
				neg    = tri_w[33];
			end
			mwg_pkg::SHAPE_SAW:      ns_mag = ph[31] ? (32'd0 - ph) : ph;
			default:                 ns_mag = '0;
		endcase

		// Full scale is 2^m - 1, so the product is a shift and a subtract
		prod_ext = V_W'(prod_q);
		case (cfg.sample_format)
			mwg_pkg::FMT_U8:  v_next = (prod_ext << 7) - prod_ext;
			mwg_pkg::FMT_S16: v_next = (prod_ext << 15) - prod_ext;
			default:          v_next = (prod_ext << 31) - prod_ext;
		endcase

		// Half-up rounding of the signed value
		q = v_q[V_W-1:47];
		if (neg_q)
			round_up = v_q[46] && (|v_q[45:0]);
		else
			round_up = v_q[46];
		if (neg_q)
			round_next = -$signed({2'b00, q}) - R_W'(round_up);
		else
			round_next = $signed({2'b00, q}) + R_W'(round_up);

		case (cfg.sample_format)
			mwg_pkg::FMT_U8: begin
				s_off = S_W'(round_q) + U8_OFFSET;
				s_lo  = U8_LO;
				s_hi  = U8_HI;
			end
			mwg_pkg::FMT_S16: begin
				s_off = S_W'(round_q);
				s_lo  = S16_LO;
				s_hi  = S16_HI;
			end
			default: begin
				s_off = S_W'(round_q);
				s_lo  = S32_LO;
				s_hi  = S32_HI;
			end
		endcase
		if (s_off < s_lo)
			s_clamped = s_lo;
		else if (s_off > s_hi)
			s_clamped = s_hi;
		else
			s_clamped = s_off;
	end

	always_ff @(posedge clk) begin
		if (pop)
			rom_q <= SINE_ROM[rom_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						count_q  <= head.count;
						neg_q    <= neg;
						ns_mag_q <= ns_mag;
						state_q  <= ST_WAVE;
					end
				end
				ST_WAVE: begin
					mag_q   <= (cfg.wave_shape == mwg_pkg::SHAPE_SINE) ? rom_q : ns_mag_q;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(mag_q) * PROD_W'(cfg.amplitude_gain);
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					v_q     <= v_next;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_next;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					sample_q <= mwg_pkg::SAMPLE_W'(s_clamped);
					ch_q     <= '0;
					last_q   <= (count_q == CNT_W'(1));
					valid_q  <= 1'b1;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						if (last_q) begin
							valid_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							ch_q   <= ch_q + CNT_W'(1);
							last_q <= (CNT_W'(ch_q + CNT_W'(2)) == count_q);
						end
					end
				end
				default: begin
					valid_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = valid_q;
	assign sample_value  = $signed(sample_q);
	assign channel_index = mwg_pkg::CH_W'(ch_q);
	assign last_channel  = last_q;

endmodule

`default_nettype wire

/* rtl/multi_waveform_generator.sv */
// Top level of the multi-waveform DDS generator: config registers, front,
// request queue and back. Depends on mwg_pkg, mwg_front, mwg_queue, mwg_back.
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   ------------------------------------------
// in        in_valid / in_stall  restart
// out       out_valid/out_stall  sample_value, channel_index, last_channel
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each tick request runs through the back sequencer: pop and sine ROM read,
// waveform select, gain multiply, full-scale shift-subtract, round,
// offset/clamp, then N channel copies, one per cycle while out_stall is low
// (N = resolved channel count, 1..8). The front keeps accepting while the
// two-entry queue has room, so in_stall only rises when two requests wait.
// arst_n clears phase, queue, sequencer and config registers to defaults.
// cfg_ready is always high; writes are expected only while the block is idle.

module multi_waveform_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// tick requests
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                restart,
	// samples
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [mwg_pkg::SAMPLE_W-1:0]      sample_value,
	output logic [mwg_pkg::CH_W-1:0]                 channel_index,
	output logic                                     last_channel,
	// register writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mwg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mwg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	mwg_pkg::cfg_t cfg_q;
	mwg_pkg::job_t push_data;
	mwg_pkg::job_t head;
	logic          push;
	logic          pop;
	logic          queue_full;
	logic          queue_empty;

	assign cfg_ready = 1'b1;

	// Register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_shape     <= mwg_pkg::SHAPE_SINE;
			cfg_q.sample_format  <= mwg_pkg::FMT_S16;
			cfg_q.phase_step     <= '0;
			cfg_q.amplitude_gain <= mwg_pkg::GAIN_W'(65536);
			cfg_q.channel_count  <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mwg_pkg::REG_WAVE_SHAPE:     cfg_q.wave_shape     <= cfg_data[1:0];
				mwg_pkg::REG_SAMPLE_FORMAT:  cfg_q.sample_format  <= cfg_data[1:0];
				mwg_pkg::REG_PHASE_STEP:     cfg_q.phase_step     <= cfg_data;
				mwg_pkg::REG_AMPLITUDE_GAIN: cfg_q.amplitude_gain <= cfg_data[16:0];
				mwg_pkg::REG_CHANNEL_COUNT:  cfg_q.channel_count  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Front: phase accumulator, restart handling and channel-count resolution
	mwg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	// Decouples front from the multi-cycle back end
	mwg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (queue_empty)
	);

	// Back: waveform, scaling, rounding and per-channel emission
	mwg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.queue_empty   (queue_empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_value  (sample_value),
		.channel_index (channel_index),
		.last_channel  (last_channel)
	);

endmodule

`default_nettype wire
